FILE: sv/settling_time_finder_unit_defines.svh
// ----------------------------------------------------------------------------
// settling time finder assertion macros
// clocked assertion helpers shared by the rtl files, compiled out with
// NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SETTLING_TIME_FINDER_UNIT_DEFINES_SVH
`define SETTLING_TIME_FINDER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFT_ASSERT(lbl, prop, msg)
`define SFT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/sft_pkg.sv
// ----------------------------------------------------------------------------
// settling time finder package
// sizes, widths and the structs passed between the store, divider and top
// ----------------------------------------------------------------------------
`default_nettype none

package sft_pkg;

  localparam int MAX_SAMPLES   = 2048;
  localparam int WINDOW_LENGTH = 20;

  localparam int ADDR_W   = $clog2(MAX_SAMPLES);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int VOLT_W   = 16;
  localparam int TIME_W   = 32;
  localparam int MARGIN_W = 16;
  localparam int INDEX_W  = 11;
  localparam int SUM_W    = VOLT_W + $clog2(WINDOW_LENGTH);
  localparam int RUN_W    = $clog2(WINDOW_LENGTH + 1);
  localparam int FACTOR_W = MARGIN_W + 1;
  localparam int PROD_W   = VOLT_W + FACTOR_W;

  // scaled reciprocal of the window length, exact for every window sum
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int RECIP_W     = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd3277;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VOLT_W-1:0] voltage;
    logic [TIME_W-1:0] stamp;
  } sft_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sft_div_t;

endpackage

`default_nettype wire

FILE: sv/sft_store.sv
// ----------------------------------------------------------------------------
// sample store
// voltage and timestamp memories, one write port and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module sft_store (
  input  wire logic                          clk,
  input  wire sft_pkg::sft_wr_t              wr,
  input  wire logic [sft_pkg::ADDR_W-1:0]    rd_addr,
  output logic      [sft_pkg::VOLT_W-1:0]    rd_voltage,
  output logic      [sft_pkg::TIME_W-1:0]    rd_stamp
);

  logic [sft_pkg::VOLT_W-1:0] voltage_mem [sft_pkg::MAX_SAMPLES];
  logic [sft_pkg::TIME_W-1:0] stamp_mem   [sft_pkg::MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      voltage_mem[wr.addr] <= wr.voltage;
      stamp_mem[wr.addr]   <= wr.stamp;
    end
  end

  always_ff @(posedge clk) begin
    rd_voltage <= voltage_mem[rd_addr];
    rd_stamp   <= stamp_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/sft_div.sv
// ----------------------------------------------------------------------------
// window mean divider
// divides the window sum by the window length with one multiply by a scaled
// reciprocal, quotient registered in the cycle after go
// ----------------------------------------------------------------------------
`default_nettype none

module sft_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [sft_pkg::SUM_W-1:0]  dividend,
  output logic      [sft_pkg::SUM_W-1:0]  quotient,
  output sft_pkg::sft_div_t               status
);

  localparam int SCALED_W = sft_pkg::SUM_W + sft_pkg::RECIP_W;

  logic [SCALED_W-1:0] scaled;
  logic                done;

  assign scaled = SCALED_W'(dividend) * SCALED_W'(sft_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= sft_pkg::SUM_W'(scaled >> sft_pkg::RECIP_SHIFT);
    end
  end

  assign status.busy = go;
  assign status.done = done;

endmodule

`default_nettype wire

FILE: sv/settling_time_finder_unit.sv
// ----------------------------------------------------------------------------
// settling time finder
// captures timestamped voltage samples, then finds where the response
// settles inside a band around the mean of the final window
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low; the word with
// last_sample set closes the capture and raises busy. The block then reads
// back the last window, takes the window mean with one multiply by the
// reciprocal of the window length, forms the two band products on one
// multiplier, scans the store one sample per cycle until the first full
// in-band run or the end, reads two timestamps and registers the result,
// which is shown for one cycle on done. A capture shorter than the window
// goes straight to the result step.
// The store has a single read port, which sets the scan pace. The receiver
// cannot stall: each result word is valid in the cycle done is high and
// holds until the next result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "settling_time_finder_unit_defines.svh"

module settling_time_finder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [sft_pkg::VOLT_W-1:0]      sample_voltage,
  input  wire logic [sft_pkg::TIME_W-1:0]      sample_time,
  input  wire logic                            last_sample,
  input  wire logic                            cfg_write,
  input  wire logic [sft_pkg::MARGIN_W-1:0]    cfg_data,
  output logic                                 done,
  output logic      [sft_pkg::INDEX_W-1:0]     settle_index,
  output logic      [sft_pkg::TIME_W-1:0]      settle_ticks,
  output logic                                 settled,
  output logic                                 too_short,
  output logic                                 overflowed
);

  localparam logic [3:0] S_CAPTURE = 4'd0;
  localparam logic [3:0] S_WIN     = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_MULHI   = 4'd3;
  localparam logic [3:0] S_MULLO   = 4'd4;
  localparam logic [3:0] S_SCAN    = 4'd5;
  localparam logic [3:0] S_T0      = 4'd6;
  localparam logic [3:0] S_TIDX    = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  localparam int ADDR_W = sft_pkg::ADDR_W;
  localparam int CNT_W  = sft_pkg::CNT_W;
  localparam int VOLT_W = sft_pkg::VOLT_W;
  localparam int PROD_W = sft_pkg::PROD_W;
  localparam int RUN_W  = sft_pkg::RUN_W;

  logic [3:0]                    state;
  logic [sft_pkg::MARGIN_W-1:0]  error_margin;
  logic [CNT_W-1:0]              sample_count;
  logic                          overflow_seen;
  logic [CNT_W-1:0]              n_held;
  logic                          short_cap;
  logic                          ovf_cap;
  logic [RUN_W-1:0]              win_k;
  logic [sft_pkg::SUM_W-1:0]     sum;
  logic [VOLT_W-1:0]             vmin;
  logic [VOLT_W-1:0]             vmax;
  logic                          div_go;
  logic [VOLT_W-1:0]             mean;
  logic [PROD_W-1:0]             hi_prod;
  logic [PROD_W-1:0]             lo_prod;
  logic [CNT_W-1:0]              scan_cnt;
  logic                          ev_valid;
  logic [ADDR_W-1:0]             ev_idx;
  logic [RUN_W-1:0]              run;
  logic [ADDR_W-1:0]             idx;
  logic                          found;
  logic [sft_pkg::TIME_W-1:0]    t0;

  logic                          accept;
  logic                          room;
  logic [CNT_W-1:0]              n_after;
  logic [ADDR_W-1:0]             first;
  logic [ADDR_W-1:0]             rd_addr;
  logic [VOLT_W-1:0]             rd_voltage;
  logic [sft_pkg::TIME_W-1:0]    rd_stamp;
  logic [sft_pkg::SUM_W-1:0]     quotient;
  sft_pkg::sft_div_t             div_st;
  sft_pkg::sft_wr_t              wr;
  logic [sft_pkg::FACTOR_W-1:0]  factor;
  logic [PROD_W-1:0]             product;
  logic [PROD_W-1:0]             v_scaled;
  logic                          in_band;
  logic [RUN_W-1:0]              run_inc;

  assign busy    = (state != S_CAPTURE);
  assign accept  = start && !busy;
  assign room    = sample_count < CNT_W'(sft_pkg::MAX_SAMPLES);
  assign n_after = sample_count + CNT_W'(room);
  assign first   = ADDR_W'(n_held - CNT_W'(sft_pkg::WINDOW_LENGTH));

  assign wr.en      = accept && room;
  assign wr.addr    = ADDR_W'(sample_count);
  assign wr.voltage = sample_voltage;
  assign wr.stamp   = sample_time;

  always_comb begin
    case (state)
      S_WIN:   rd_addr = first + ADDR_W'(win_k);
      S_SCAN:  rd_addr = ADDR_W'(scan_cnt);
      S_TIDX:  rd_addr = idx;
      default: rd_addr = '0;
    endcase
  end

  // shared band multiplier, upper factor then lower factor
  always_comb begin
    if (state == S_MULHI) begin
      factor = sft_pkg::FACTOR_W'(17'h10000) + sft_pkg::FACTOR_W'(error_margin);
    end else begin
      factor = sft_pkg::FACTOR_W'(17'h10000) - sft_pkg::FACTOR_W'(error_margin);
    end
    product = PROD_W'(mean) * PROD_W'(factor);
  end

  assign v_scaled = {1'b0, rd_voltage, 16'h0000};
  assign in_band  = ((rd_voltage <= vmax) || (v_scaled <= hi_prod)) &&
                    ((rd_voltage >= vmin) || (v_scaled >= lo_prod));
  assign run_inc  = run + 1'b1;

  sft_store u_store (
    .clk        (clk),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .rd_voltage (rd_voltage),
    .rd_stamp   (rd_stamp)
  );

  sft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (sum),
    .quotient (quotient),
    .status   (div_st)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CAPTURE;
      error_margin  <= sft_pkg::MARGIN_RESET;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      done          <= 1'b0;
      div_go        <= 1'b0;
      ev_valid      <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      if (cfg_write) begin
        error_margin <= cfg_data;
      end
      case (state)
        S_CAPTURE: begin
          if (accept) begin
            if (last_sample) begin
              sample_count  <= '0;
              overflow_seen <= 1'b0;
              state         <= (n_after < CNT_W'(sft_pkg::WINDOW_LENGTH)) ? S_OUT : S_WIN;
            end else if (room) begin
              sample_count <= sample_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        S_WIN: begin
          if (win_k == RUN_W'(sft_pkg::WINDOW_LENGTH)) begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_MULHI;
          end
        end
        S_MULHI: state <= S_MULLO;
        S_MULLO: begin
          ev_valid <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          ev_valid <= scan_cnt < n_held;
          if (ev_valid && in_band && (run_inc == RUN_W'(sft_pkg::WINDOW_LENGTH))) begin
            state <= S_T0;
          end else if (!ev_valid && (scan_cnt == n_held)) begin
            state <= S_T0;
          end
        end
        S_T0:    state <= S_TIDX;
        S_TIDX:  state <= S_OUT;
        S_OUT: begin
          done  <= 1'b1;
          state <= S_CAPTURE;
        end
        default: state <= S_CAPTURE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_CAPTURE: begin
        if (accept && last_sample) begin
          n_held    <= n_after;
          short_cap <= n_after < CNT_W'(sft_pkg::WINDOW_LENGTH);
          ovf_cap   <= overflow_seen || !room;
          win_k     <= '0;
          idx       <= '0;
          found     <= 1'b0;
        end
      end
      S_WIN: begin
        win_k <= win_k + 1'b1;
        if (win_k == '0) begin
          sum  <= '0;
          vmin <= '1;
          vmax <= '0;
        end else begin
          sum <= sum + sft_pkg::SUM_W'(rd_voltage);
          if (rd_voltage < vmin) begin
            vmin <= rd_voltage;
          end
          if (rd_voltage > vmax) begin
            vmax <= rd_voltage;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          mean <= VOLT_W'(quotient);
        end
      end
      S_MULHI: hi_prod <= product;
      S_MULLO: begin
        lo_prod  <= product;
        scan_cnt <= '0;
        run      <= '0;
      end
      S_SCAN: begin
        if (scan_cnt < n_held) begin
          ev_idx   <= ADDR_W'(scan_cnt);
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (ev_valid) begin
          if (in_band) begin
            run <= run_inc;
            if (run == '0) begin
              idx <= ev_idx;
            end
            if (run_inc == RUN_W'(sft_pkg::WINDOW_LENGTH)) begin
              found <= 1'b1;
            end
          end else begin
            run <= '0;
          end
        end
      end
      S_TIDX: t0 <= rd_stamp;
      S_OUT: begin
        settle_index <= sft_pkg::INDEX_W'(idx);
        settle_ticks <= short_cap ? '0 : rd_stamp - t0;
        settled      <= found;
        too_short    <= short_cap;
        overflowed   <= ovf_cap;
      end
      default: begin
      end
    endcase
  end

  `SFT_ASSERT(a_done_after_out, done |-> $past(state) == S_OUT, "result word without finish step")
  `SFT_ASSERT(a_short_not_settled, done |-> !(settled && too_short), "short capture marked settled")
  `SFT_ASSERT(a_div_in_div_state, div_st.busy |-> state == S_DIV, "divider running outside mean step")
  `SFT_ASSERT(a_count_bound, sample_count <= CNT_W'(sft_pkg::MAX_SAMPLES), "sample count past store size")
  `SFT_ASSERT_NEXT(a_busy_after_last, accept && last_sample, busy, "last word did not raise busy")

endmodule

`default_nettype wire
